// File: design/pat_pkg.sv
// Shared constants and types for the peer address table.
package pat_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ACT_W = 5;
	localparam int SLOT_W = 4;
	localparam int PORT_W = 16;
	localparam int ADDR_W = 64;
	localparam int V4_W = 32;
	localparam int CMD_W = 2;

	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	typedef struct packed {
		logic load;
		logic eval;
		logic commit;
	} pat_ctrl_t;

endpackage

// File: design/pat_ctrl.sv
// Controller that steps one item through capture, compare and update.
module pat_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output pat_pkg::pat_ctrl_t ctrl
);
	import pat_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		ctrl.load = start && (state_q == ST_IDLE);
		ctrl.eval = (state_q == ST_EVAL);
		ctrl.commit = (state_q == ST_COMMIT);
	end

endmodule

// File: design/pat_dp.sv
// Datapath: key capture, entry storage, parallel compare and result registers.
module pat_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pat_pkg::pat_ctrl_t          ctrl,
	input  logic                        cfg_valid,
	input  logic [pat_pkg::ACT_W-1:0]   cfg_data,
	input  logic [pat_pkg::CMD_W-1:0]   cmd,
	input  logic                        is_ipv6,
	input  logic [pat_pkg::PORT_W-1:0]  port,
	input  logic [pat_pkg::ADDR_W-1:0]  addr_high,
	input  logic [pat_pkg::ADDR_W-1:0]  addr_low,
	input  logic [pat_pkg::SLOT_W-1:0]  slot,
	output logic                        done,
	output logic                        ok,
	output logic [pat_pkg::SLOT_W-1:0]  slot_index
);
	import pat_pkg::*;

	// Captured item.
	logic [CMD_W-1:0]  cmd_q;
	logic              fam_q;
	logic [PORT_W-1:0] port_q;
	logic [ADDR_W-1:0] hi_q;
	logic [ADDR_W-1:0] lo_q;
	logic [SLOT_W-1:0] slot_q;

	logic [ACT_W-1:0] active_q;

	// Entry storage; the key fields have no reset and are read only when valid.
	logic [SLOTS-1:0]  valid_q;
	logic              ent_fam_q [SLOTS];
	logic [PORT_W-1:0] ent_port_q [SLOTS];
	logic [ADDR_W-1:0] ent_hi_q [SLOTS];
	logic [ADDR_W-1:0] ent_lo_q [SLOTS];

	logic [SLOTS-1:0] hit_vec;
	logic [SLOTS-1:0] free_vec;
	logic [SLOTS-1:0] hit_q;
	logic [SLOTS-1:0] free_q;

	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic [IDX_W-1:0] del_idx;
	logic             del_in_range;

	logic              done_q;
	logic              ok_q;
	logic [SLOT_W-1:0] slot_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd;
			fam_q <= is_ipv6;
			port_q <= port;
			hi_q <= addr_high;
			lo_q <= addr_low;
			slot_q <= slot;
		end
	end

	// One comparator per entry; only active entries take part.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			logic in_use;
			logic key_eq;
			in_use = (i < int'(active_q));
			key_eq = (ent_fam_q[i] == fam_q) && (ent_port_q[i] == port_q)
				&& (ent_lo_q[i][V4_W-1:0] == lo_q[V4_W-1:0]);
			if (fam_q) begin
				key_eq = key_eq && (ent_hi_q[i] == hi_q)
					&& (ent_lo_q[i][ADDR_W-1:V4_W] == lo_q[ADDR_W-1:V4_W]);
			end
			hit_vec[i] = in_use && valid_q[i] && key_eq;
			free_vec[i] = in_use && !valid_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.eval) begin
			hit_q <= hit_vec;
			free_q <= free_vec;
		end
	end

	// Lowest set bit wins.
	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				hit_idx = IDX_W'(i);
			end
			if (free_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign del_in_range = (int'(slot_q) < SLOTS);
	assign del_idx = IDX_W'(slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
			slot_index_q <= '0;
		end else begin
			done_q <= ctrl.commit;
			if (ctrl.commit) begin
				ok_q <= 1'b0;
				slot_index_q <= '0;
				case (cmd_q)
					CMD_LOOKUP: begin
						if (|hit_q) begin
							ok_q <= 1'b1;
							slot_index_q <= SLOT_W'(hit_idx);
						end
					end
					CMD_ADD: begin
						if (|free_q) begin
							valid_q[free_idx] <= 1'b1;
							ok_q <= 1'b1;
							slot_index_q <= SLOT_W'(free_idx);
						end
					end
					CMD_DELETE: begin
						if (del_in_range && valid_q[del_idx]) begin
							valid_q[del_idx] <= 1'b0;
							ok_q <= 1'b1;
							slot_index_q <= SLOT_W'(del_idx);
						end
					end
					default: begin
						ok_q <= 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit && (cmd_q == CMD_ADD) && (|free_q)) begin
			ent_fam_q[free_idx] <= fam_q;
			ent_port_q[free_idx] <= port_q;
			ent_hi_q[free_idx] <= hi_q;
			ent_lo_q[free_idx] <= lo_q;
		end
	end

	assign done = done_q;
	assign ok = ok_q;
	assign slot_index = slot_index_q;

endmodule

// File: design/peer_address_table_core.sv
// Top level of the peer address table: controller plus datapath.
//
// channel   direction  handshake              payload
// command   in         start & !busy          cmd, is_ipv6, port, addr_high, addr_low, slot
// result    out        done (one cycle)       ok, slot_index
// config    in         cfg_valid & cfg_ready  cfg_data (active slot count)
//
// An item passes from acceptance to its result strobe through capture, a
// parallel compare of all entries against the key, then priority encoding
// and the table update. busy is high in the compare and commit states after
// acceptance, so a new item can be accepted in the cycle its predecessor's
// result is shown. Reset clears all valid marks at once and sets the active
// count to sixteen. The receiver cannot stall the result; cfg_ready is always high.
module peer_address_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pat_pkg::CMD_W-1:0]   cmd,
	input  logic                        is_ipv6,
	input  logic [pat_pkg::PORT_W-1:0]  port,
	input  logic [pat_pkg::ADDR_W-1:0]  addr_high,
	input  logic [pat_pkg::ADDR_W-1:0]  addr_low,
	input  logic [pat_pkg::SLOT_W-1:0]  slot,
	output logic                        done,
	output logic                        ok,
	output logic [pat_pkg::SLOT_W-1:0]  slot_index,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pat_pkg::ACT_W-1:0]   cfg_data
);
	import pat_pkg::*;

	pat_ctrl_t ctrl;

	assign cfg_ready = 1'b1;

	pat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	pat_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.is_ipv6    (is_ipv6),
		.port       (port),
		.addr_high  (addr_high),
		.addr_low   (addr_low),
		.slot       (slot),
		.done       (done),
		.ok         (ok),
		.slot_index (slot_index)
	);

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the peer address table core.
module testbench;
	import pat_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RESULT_LATENCY = 3;
	localparam int POOL_DEPTH = 32;

	typedef struct {
		logic [CMD_W-1:0]  cmd;
		logic              is_v6;
		logic [PORT_W-1:0] port;
		logic [ADDR_W-1:0] hi;
		logic [ADDR_W-1:0] lo;
		logic [SLOT_W-1:0] slot;
	} peer_cmd_t;

	typedef struct {
		logic              ok;
		logic [SLOT_W-1:0] idx;
	} peer_outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] cmd = CMD_LOOKUP;
	logic is_ipv6 = 1'b0;
	logic [PORT_W-1:0] port = '0;
	logic [ADDR_W-1:0] addr_high = '0;
	logic [ADDR_W-1:0] addr_low = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic done;
	logic ok;
	logic [SLOT_W-1:0] slot_index;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ACT_W-1:0] cfg_data = '0;

	// Shadow copy of the table, updated in acceptance order.
	logic              peer_valid [SLOTS];
	logic              peer_v6 [SLOTS];
	logic [PORT_W-1:0] peer_port [SLOTS];
	logic [ADDR_W-1:0] peer_hi [SLOTS];
	logic [ADDR_W-1:0] peer_lo [SLOTS];
	logic [ACT_W-1:0]  active_count;

	peer_outcome_t pending_outcomes[$];
	peer_cmd_t key_pool[$];

	int fail_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int lookups_hit = 0, lookups_missed = 0;
	int adds_done = 0, adds_full = 0;
	int deletes_done = 0, deletes_bad = 0;
	int unused_cmds = 0;
	int count_writes = 0;

	peer_address_table_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.is_ipv6(is_ipv6),
		.port(port),
		.addr_high(addr_high),
		.addr_low(addr_low),
		.slot(slot),
		.done(done),
		.ok(ok),
		.slot_index(slot_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("** peer_address_table_core: FAILED **");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {$urandom(), $urandom()};
	endfunction

	function automatic peer_cmd_t make_cmd(logic [CMD_W-1:0] c, logic v6, logic [PORT_W-1:0] p,
			logic [ADDR_W-1:0] h, logic [ADDR_W-1:0] l, logic [SLOT_W-1:0] s);
		peer_cmd_t k;
		k.cmd = c;
		k.is_v6 = v6;
		k.port = p;
		k.hi = h;
		k.lo = l;
		k.slot = s;
		return k;
	endfunction

	function automatic bit key_hits(int i, peer_cmd_t k);
		if (peer_v6[i] != k.is_v6 || peer_port[i] != k.port)
			return 1'b0;
		if (!k.is_v6)
			return peer_lo[i][V4_W-1:0] == k.lo[V4_W-1:0];
		return peer_hi[i] == k.hi && peer_lo[i] == k.lo;
	endfunction

	task automatic reset_table_model();
		for (int i = 0; i < SLOTS; i++) begin
			peer_valid[i] = 1'b0;
			peer_v6[i] = 1'b0;
			peer_port[i] = '0;
			peer_hi[i] = '0;
			peer_lo[i] = '0;
		end
		active_count = ACT_RESET;
	endtask

	// Applies one accepted item to the shadow table and returns its outcome.
	task automatic apply_table_op(input peer_cmd_t k, output peer_outcome_t r);
		int in_use;
		in_use = (active_count > SLOTS) ? SLOTS : active_count;
		r.ok = 1'b0;
		r.idx = '0;
		case (k.cmd)
			CMD_LOOKUP: begin
				for (int i = 0; i < in_use && !r.ok; i++)
					if (peer_valid[i] && key_hits(i, k)) begin
						r.ok = 1'b1;
						r.idx = SLOT_W'(i);
					end
				if (r.ok) lookups_hit++;
				else lookups_missed++;
			end
			CMD_ADD: begin
				for (int i = 0; i < in_use && !r.ok; i++)
					if (!peer_valid[i]) begin
						peer_valid[i] = 1'b1;
						peer_v6[i] = k.is_v6;
						peer_port[i] = k.port;
						peer_hi[i] = k.hi;
						peer_lo[i] = k.lo;
						r.ok = 1'b1;
						r.idx = SLOT_W'(i);
					end
				if (r.ok) adds_done++;
				else adds_full++;
			end
			CMD_DELETE: begin
				if (int'(k.slot) < SLOTS && peer_valid[k.slot]) begin
					peer_valid[k.slot] = 1'b0;
					r.ok = 1'b1;
					r.idx = k.slot;
					deletes_done++;
				end else begin
					deletes_bad++;
				end
			end
			default: unused_cmds++;
		endcase
	endtask

	// Holds start high until the item is taken; start stays high afterward so
	// that a following item can go back to back.
	task automatic send_cmd(input peer_cmd_t k);
		peer_outcome_t r;
		@(negedge clk);
		start = 1'b1;
		cmd = k.cmd;
		is_ipv6 = k.is_v6;
		port = k.port;
		addr_high = k.hi;
		addr_low = k.lo;
		slot = k.slot;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		apply_table_op(k, r);
		pending_outcomes.push_back(r);
		items_sent++;
	endtask

	// Idle cycles with start low; the payload carries junk meanwhile.
	task automatic idle_cycles(int n);
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			cmd = CMD_W'($urandom());
			is_ipv6 = 1'($urandom());
			port = PORT_W'($urandom());
			addr_high = rand_addr();
			addr_low = rand_addr();
			slot = SLOT_W'($urandom());
			repeat (n - 1) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(24, 4);
	endfunction

	task automatic wait_idle();
		@(negedge clk);
		start = 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 1) @(posedge clk);
	endtask

	task automatic write_active_count(logic [ACT_W-1:0] value);
		wait_idle();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		active_count = value;
		count_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data = ACT_W'($urandom());
	endtask

	always @(posedge clk) begin
		peer_outcome_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_outcomes.size() == 0) begin
				$error("result with no item outstanding: ok=%0d slot_index=%0d", ok, slot_index);
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, ok);
					fail_count++;
				end
				if (slot_index !== want.idx) begin
					$error("slot_index: expected %0d, got %0d", want.idx, slot_index);
					fail_count++;
				end
			end
		end else if (arst_n && done !== 1'b0) begin
			$error("done: expected 0 or 1, got %b", done);
			fail_count++;
		end
	end

	function automatic peer_cmd_t random_key(logic [CMD_W-1:0] c);
		peer_cmd_t k;
		int r;
		r = $urandom_range(9);
		k = make_cmd(c, 1'($urandom()), PORT_W'($urandom()), rand_addr(), rand_addr(),
			SLOT_W'($urandom()));
		if (r == 0) k.port = '0;
		else if (r == 1) k.port = '1;
		return k;
	endfunction

	// A lookup derived from a stored key: exact, or changed so that it
	// should hit or miss for a particular reason.
	function automatic peer_cmd_t lookup_variant(peer_cmd_t base);
		peer_cmd_t k;
		k = base;
		k.cmd = CMD_LOOKUP;
		k.slot = SLOT_W'($urandom());
		case ($urandom_range(5))
			0, 1: ;
			2: begin
				// Bits outside the IPv4 compare; an IPv6 key misses.
				k.hi = rand_addr();
				k.lo[ADDR_W-1:V4_W] = $urandom();
			end
			3: begin
				if ($urandom_range(1)) k.hi[$urandom_range(ADDR_W - 1)] ^= 1'b1;
				else k.lo[$urandom_range(ADDR_W - 1)] ^= 1'b1;
			end
			4: k.is_v6 = ~k.is_v6;
			default: k.port[$urandom_range(PORT_W - 1)] ^= 1'b1;
		endcase
		return k;
	endfunction

	function automatic peer_cmd_t next_random_cmd();
		peer_cmd_t k;
		int in_use, filled, r, p_add, p_del;
		int taken[$];
		in_use = (active_count > SLOTS) ? SLOTS : active_count;
		filled = 0;
		for (int i = 0; i < SLOTS; i++)
			if (peer_valid[i]) begin
				taken.push_back(i);
				if (i < in_use) filled++;
			end
		p_add = (2 * filled < in_use) ? 45 : 20;
		p_del = (4 * filled >= 3 * in_use) ? 35 : 15;
		r = $urandom_range(99);
		if (r < 5) begin
			k = random_key(CMD_W'($urandom()));
		end else if (r < 5 + p_add) begin
			if (key_pool.size() != 0 && $urandom_range(3) == 0)
				k = key_pool[$urandom_range(key_pool.size() - 1)];
			else
				k = random_key(CMD_ADD);
			k.cmd = CMD_ADD;
			k.slot = SLOT_W'($urandom());
			key_pool.push_back(k);
			if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
		end else if (r < 5 + p_add + p_del) begin
			k = random_key(CMD_DELETE);
			if (taken.size() != 0 && $urandom_range(9) < 7)
				k.slot = SLOT_W'(taken[$urandom_range(taken.size() - 1)]);
		end else if (key_pool.size() != 0 && $urandom_range(9) < 7) begin
			k = lookup_variant(key_pool[$urandom_range(key_pool.size() - 1)]);
		end else begin
			k = random_key(CMD_LOOKUP);
		end
		return k;
	endfunction

	task automatic test_empty_table();
		send_cmd(random_key(CMD_LOOKUP));
		idle_cycles(pick_gap());
		send_cmd(make_cmd(CMD_DELETE, 1'b0, '0, '0, '0, 4'd15));
		send_cmd(make_cmd(CMD_UNUSED, 1'b1, '1, '1, '1, 4'd0));
	endtask

	task automatic test_small_table();
		logic [ADDR_W-1:0] ones;
		ones = '1;
		write_active_count(5'd2);
		send_cmd(make_cmd(CMD_ADD, 1'b0, 16'h0000, ones, 64'h0, 4'd0));
		send_cmd(make_cmd(CMD_ADD, 1'b1, 16'hFFFF, ones, ones, 4'd0));
		// The table is full now.
		send_cmd(make_cmd(CMD_ADD, 1'b1, 16'h1234, 64'h1, 64'h2, 4'd0));
		// Only the low 32 bits of an IPv4 address take part in the compare.
		send_cmd(make_cmd(CMD_LOOKUP, 1'b0, 16'h0000, 64'h0, 64'hFFFF_FFFF_0000_0000, 4'd9));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b1, 16'hFFFF, ones, ones, 4'd0));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b1, 16'hFFFF, 64'h7FFF_FFFF_FFFF_FFFF, ones, 4'd0));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b0, 16'hFFFF, ones, ones, 4'd0));
		send_cmd(make_cmd(CMD_DELETE, 1'b0, '0, '0, '0, 4'd0));
		// Duplicate key: the lower entry wins the lookup.
		send_cmd(make_cmd(CMD_ADD, 1'b1, 16'hFFFF, ones, ones, 4'd0));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b1, 16'hFFFF, ones, ones, 4'd0));
	endtask

	task automatic test_active_extremes();
		logic [ADDR_W-1:0] ones;
		ones = '1;
		write_active_count(5'd0);
		send_cmd(make_cmd(CMD_LOOKUP, 1'b1, 16'hFFFF, ones, ones, 4'd0));
		send_cmd(make_cmd(CMD_ADD, 1'b0, 16'h8000, 64'h0, 64'h8000_0000, 4'd0));
		// Entry one lies outside the active count but is still cleared.
		send_cmd(make_cmd(CMD_DELETE, 1'b0, '0, '0, '0, 4'd1));
		write_active_count(5'd31);
		send_cmd(make_cmd(CMD_ADD, 1'b0, 16'h8000, 64'h0, 64'h8000_0000, 4'd0));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b0, 16'h8001, 64'h0, 64'h8000_0000, 4'd0));
		send_cmd(make_cmd(CMD_LOOKUP, 1'b0, 16'h8000, ones, 64'h1234_5678_8000_0000, 4'd0));
		send_cmd(make_cmd(CMD_DELETE, 1'b0, '0, '0, '0, 4'd15));
	endtask

	task automatic test_random_traffic();
		logic [ACT_W-1:0] counts [11];
		bit gappy;
		counts = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd17, 5'd2, 5'd12, 5'd0, 5'd9, 5'd31, 5'd16};
		foreach (counts[p]) begin
			write_active_count(counts[p]);
			gappy = (p % 3) != 1;
			for (int n = 0; n < 100; n++) begin
				send_cmd(next_random_cmd());
				if (gappy) idle_cycles(pick_gap());
			end
		end
	endtask

	initial begin
		reset_table_model();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_table();
		test_small_table();
		test_active_extremes();
		test_random_traffic();
		wait_idle();
		repeat (2 * RESULT_LATENCY) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$error("%0d results never arrived", pending_outcomes.size());
			fail_count++;
		end
		$display("Sent %0d items over %0d active-count settings; %0d results checked.",
			items_sent, count_writes + 1, results_seen);
		$display("Lookups %0d hit / %0d missed, adds %0d / %0d full, deletes %0d / %0d bad, %0d unused.",
			lookups_hit, lookups_missed, adds_done, adds_full, deletes_done, deletes_bad,
			unused_cmds);
		if (fail_count == 0)
			$display("** peer_address_table_core: PASSED **");
		else
			$display("** peer_address_table_core: FAILED **");
		$finish;
	end

endmodule
